>>> rtl/bso_pkg.sv
// Shared types for the data-processing operand shifter: channel payloads,
// the decoded control word and its small code sets. No dependencies.
`timescale 1ns / 1ps

package bso_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ROT_W  = 5;

  // Shift type codes from operand bits [6:5].
  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  typedef struct packed {
    logic        immediate_form;
    logic [11:0] operand_bits;
    logic [31:0] rm_value;
    logic [7:0]  rs_low_byte;
    logic        carry_in;
    logic        set_flags;
  } in_item_t;

  typedef struct packed {
    logic [31:0] operand_value;
    logic        carry_out;
  } out_item_t;

  // Which bits of the rotated value survive; the rest take the fill.
  typedef enum logic [1:0] {
    MASK_ALL,
    MASK_NONE,
    MASK_LOW,
    MASK_HIGH
  } mask_kind_t;

  // Where the shifter carry comes from.
  typedef enum logic [1:0] {
    CY_CIN,
    CY_ZERO,
    CY_ROT_LSB,
    CY_ROT_MSB
  } cy_sel_t;

  typedef struct packed {
    logic [DATA_W-1:0] src;
    logic [ROT_W-1:0]  rot;
    mask_kind_t        mask_kind;
    logic [ROT_W-1:0]  mask_amt;
    logic              fill_sign;
    logic              rrx;
    cy_sel_t           cy_sel;
    logic              carry_in;
    logic              set_flags;
  } dec_t;

endpackage

>>> rtl/bso_decode.sv
// Operand decode: turns an operand encoding into a right-rotate amount, a
// keep mask, a fill rule and a carry source. Uses bso_pkg.
`timescale 1ns / 1ps

module bso_decode (
  input  bso_pkg::in_item_t item,
  output bso_pkg::dec_t     dec
);

  logic [1:0] shift_type;
  logic       by_reg;
  logic [4:0] sh_imm;
  logic [7:0] amt;
  logic [4:0] amt_lo;

  assign shift_type = item.operand_bits[6:5];
  assign by_reg     = item.operand_bits[4];
  assign sh_imm     = item.operand_bits[11:7];
  assign amt_lo     = amt[4:0];

  // An immediate LSR or ASR by zero encodes a shift by 32.
  always_comb begin
    if (by_reg) begin
      amt = item.rs_low_byte;
    end else if (sh_imm == 5'd0 &&
                 (shift_type == bso_pkg::SHIFT_LSR || shift_type == bso_pkg::SHIFT_ASR)) begin
      amt = 8'd32;
    end else begin
      amt = {3'b000, sh_imm};
    end
  end

  always_comb begin
    dec.src       = item.rm_value;
    dec.rot       = '0;
    dec.mask_kind = bso_pkg::MASK_ALL;
    dec.mask_amt  = '0;
    dec.fill_sign = 1'b0;
    dec.rrx       = 1'b0;
    dec.cy_sel    = bso_pkg::CY_CIN;
    dec.carry_in  = item.carry_in;
    dec.set_flags = item.set_flags;

    if (item.immediate_form) begin
      dec.src = {24'd0, item.operand_bits[7:0]};
      dec.rot = {item.operand_bits[11:8], 1'b0};
      if (item.operand_bits[11:8] != 4'd0) begin
        dec.cy_sel = bso_pkg::CY_ROT_MSB;
      end
    end else if (amt == 8'd0) begin
      // Immediate ROR by zero is RRX; every other zero amount passes through.
      if (!by_reg && shift_type == bso_pkg::SHIFT_ROR) begin
        dec.rot    = 5'd1;
        dec.rrx    = 1'b1;
        dec.cy_sel = bso_pkg::CY_ROT_MSB;
      end
    end else begin
      case (shift_type)
        bso_pkg::SHIFT_LSL: begin
          if (amt < 8'd32) begin
            // A left shift by n is a right rotate by 32 - n with the low bits cleared.
            dec.rot       = 5'd0 - amt_lo;
            dec.mask_kind = bso_pkg::MASK_HIGH;
            dec.mask_amt  = amt_lo;
            dec.cy_sel    = bso_pkg::CY_ROT_LSB;
          end else begin
            dec.mask_kind = bso_pkg::MASK_NONE;
            dec.cy_sel    = (amt == 8'd32) ? bso_pkg::CY_ROT_LSB : bso_pkg::CY_ZERO;
          end
        end
        bso_pkg::SHIFT_LSR: begin
          if (amt < 8'd32) begin
            dec.rot       = amt_lo;
            dec.mask_kind = bso_pkg::MASK_LOW;
            dec.mask_amt  = amt_lo;
            dec.cy_sel    = bso_pkg::CY_ROT_MSB;
          end else begin
            dec.mask_kind = bso_pkg::MASK_NONE;
            dec.cy_sel    = (amt == 8'd32) ? bso_pkg::CY_ROT_MSB : bso_pkg::CY_ZERO;
          end
        end
        bso_pkg::SHIFT_ASR: begin
          dec.fill_sign = 1'b1;
          dec.cy_sel    = bso_pkg::CY_ROT_MSB;
          if (amt < 8'd32) begin
            dec.rot       = amt_lo;
            dec.mask_kind = bso_pkg::MASK_LOW;
            dec.mask_amt  = amt_lo;
          end else begin
            dec.mask_kind = bso_pkg::MASK_NONE;
          end
        end
        default: begin
          // A multiple of 32 rotates by zero, and the carry is then bit 31.
          dec.rot    = amt_lo;
          dec.cy_sel = bso_pkg::CY_ROT_MSB;
        end
      endcase
    end
  end

endmodule

>>> rtl/barrel_shifter_operand_top.sv
// Top level of the data-processing operand shifter: three register stages
// (decode, rotate and mask, merge and carry). Uses bso_pkg and bso_decode.
`timescale 1ns / 1ps

// Each transfer in produces exactly one transfer out, once it has passed the
// stage 1, stage 2 and output registers. A new item is taken every clock cycle
// while in_stall is low; the three stages hold one item each (decode, barrel
// rotate with mask build, final merge and carry select), and a stall at the
// output backs up only as far as the first stage that has an empty slot.
module barrel_shifter_operand_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bso_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bso_pkg::out_item_t   out_data
);

  bso_pkg::dec_t dec_nxt;
  bso_pkg::dec_t s1_r;
  logic          s1_valid_r;

  logic [31:0]         s2_rot_r;
  logic [31:0]         s2_mask_r;
  logic                s2_fill_r;
  logic                s2_rrx_r;
  bso_pkg::cy_sel_t    s2_cy_sel_r;
  logic                s2_cin_r;
  logic                s2_sf_r;
  logic                s2_valid_r;

  logic [31:0]         rot_nxt;
  logic [31:0]         mask_nxt;

  bso_pkg::out_item_t  out_r;
  bso_pkg::out_item_t  out_nxt;
  logic                out_valid_r;

  logic                en3;
  logic                en2;
  logic                en1;

  logic [31:0]         merged;
  logic                shifter_cy;

  // A stage loads when it is empty or its contents move on this cycle.
  assign en3 = !out_valid_r || !out_stall;
  assign en2 = !s2_valid_r || en3;
  assign en1 = !s1_valid_r || en2;
  assign in_stall = !en1;

  bso_decode u_decode (
    .item (in_data),
    .dec  (dec_nxt)
  );

  // Stage 1: decoded control word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_valid;
    end
    if (en1 && in_valid) begin
      s1_r <= dec_nxt;
    end
  end

  // Stage 2: barrel rotate and keep mask.
  always_comb begin
    rot_nxt = (s1_r.src >> s1_r.rot) | (s1_r.src << (6'd32 - {1'b0, s1_r.rot}));
    case (s1_r.mask_kind)
      bso_pkg::MASK_ALL:  mask_nxt = 32'hFFFF_FFFF;
      bso_pkg::MASK_NONE: mask_nxt = 32'h0000_0000;
      bso_pkg::MASK_LOW:  mask_nxt = 32'hFFFF_FFFF >> s1_r.mask_amt;
      bso_pkg::MASK_HIGH: mask_nxt = 32'hFFFF_FFFF << s1_r.mask_amt;
      default:            mask_nxt = 32'hFFFF_FFFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en2 && s1_valid_r) begin
      s2_rot_r    <= rot_nxt;
      s2_mask_r   <= mask_nxt;
      s2_fill_r   <= s1_r.fill_sign & s1_r.src[31];
      s2_rrx_r    <= s1_r.rrx;
      s2_cy_sel_r <= s1_r.cy_sel;
      s2_cin_r    <= s1_r.carry_in;
      s2_sf_r     <= s1_r.set_flags;
    end
  end

  // Stage 3: merge with the fill, insert the RRX carry, pick the carry.
  always_comb begin
    merged = (s2_rot_r & s2_mask_r) | ({32{s2_fill_r}} & ~s2_mask_r);
    if (s2_rrx_r) begin
      merged[31] = s2_cin_r;
    end
    case (s2_cy_sel_r)
      bso_pkg::CY_CIN:     shifter_cy = s2_cin_r;
      bso_pkg::CY_ZERO:    shifter_cy = 1'b0;
      bso_pkg::CY_ROT_LSB: shifter_cy = s2_rot_r[0];
      bso_pkg::CY_ROT_MSB: shifter_cy = s2_rot_r[31];
      default:             shifter_cy = s2_cin_r;
    endcase
    out_nxt.operand_value = merged;
    out_nxt.carry_out     = s2_sf_r ? shifter_cy : s2_cin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s2_valid_r;
    end
    if (en3 && s2_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
